@@ src/ptgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgc_pkg
// Shared types and constants for the point track gesture classifier.
// ----------------------------------------------------------------------------
package ptgc_pkg;

  localparam int WINDOW_DEPTH_DEF = 50;
  localparam int COORD_BITS_DEF   = 11;

  localparam int MINOR_W  = 12;
  localparam int MAJOR_W  = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int GEST_W   = 3;

  localparam logic [MINOR_W-1:0] MINOR_RST = MINOR_W'(50);
  localparam logic [MAJOR_W-1:0] MAJOR_RST = MAJOR_W'(300);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MINOR = 8'd0,
    REG_MAJOR = 8'd1
  } reg_idx_t;

  typedef enum logic [GEST_W-1:0] {
    GEST_NONE     = 3'd0,
    GEST_UP       = 3'd1,
    GEST_DOWN     = 3'd2,
    GEST_LEFT     = 3'd3,
    GEST_RIGHT    = 3'd4,
    GEST_ZOOM_IN  = 3'd5,
    GEST_ZOOM_OUT = 3'd6
  } gesture_t;

  typedef struct packed {
    logic [MINOR_W-1:0] minor;
    logic [MAJOR_W-1:0] major;
  } limits_t;

endpackage

@@ src/ptgc_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgc interfaces
// Valid/ready channels for frames, gestures and register writes.
// ----------------------------------------------------------------------------
interface ptgc_in_if #(parameter int COORD_BITS = ptgc_pkg::COORD_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] red_x;
  logic [COORD_BITS-1:0] red_y;
  logic [COORD_BITS-1:0] green_x;
  logic [COORD_BITS-1:0] green_y;
  modport source (output valid, red_x, red_y, green_x, green_y, input ready);
  modport sink   (input valid, red_x, red_y, green_x, green_y, output ready);
endinterface

interface ptgc_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptgc_pkg::GEST_W-1:0]   gesture;
  modport source (output valid, gesture, input ready);
  modport sink   (input valid, gesture, output ready);
endinterface

interface ptgc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ptgc_pkg::CFG_IDX_W-1:0]  index;
  logic [ptgc_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ptgc_win_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgc_win_mem
// Single write / single read window memory, registered read data.
// ----------------------------------------------------------------------------
module ptgc_win_mem #(
  parameter int DEPTH = ptgc_pkg::WINDOW_DEPTH_DEF,
  parameter int WIDTH = 67
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/ptgc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgc_core
// Window sequencer: pushes a frame into the circular window, then walks the
// older entries once for the zoom and scroll tests.
// ----------------------------------------------------------------------------
module ptgc_core #(
  parameter int WINDOW_DEPTH = ptgc_pkg::WINDOW_DEPTH_DEF,
  parameter int COORD_BITS   = ptgc_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ptgc_pkg::limits_t lim,
  ptgc_in_if.sink          in_ch,
  ptgc_out_if.source       out_ch
);

  localparam int C   = COORD_BITS;
  localparam int SW  = 2 * C + 1;
  localparam int MW  = 4 * C + SW;
  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int TW0 = C + $clog2(WINDOW_DEPTH) + 2;
  localparam int TW  = (TW0 > 18) ? TW0 : 18;
  localparam logic [AW-1:0] LAST = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(WINDOW_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_PUSH, S_WALK, S_DONE} state_t;

  state_t              state_r;
  logic [C-1:0]        rx_r, ry_r, gx_r, gy_r;
  logic [AW-1:0]       head_r;
  logic [CW-1:0]       cnt_r;
  logic [SW-1:0]       s0_r;
  logic [C-1:0]        px_r, py_r;
  logic signed [TW-1:0] tx_r, ty_r;
  ptgc_pkg::gesture_t  zoom_r, scroll_r, gest_r;
  logic [AW:0]         rd_i_r;
  logic                pv_r;
  logic [AW-1:0]       pa_r;
  logic                out_valid_r;

  logic                mem_we;
  logic [AW-1:0]       waddr, raddr, head_inc;
  logic [MW-1:0]       wdata, rdata;

  ptgc_win_mem #(.DEPTH(WINDOW_DEPTH), .WIDTH(MW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Entry fields, masked to zero past the fill count
  logic          ent_ok;
  logic [C-1:0]  e_rx, e_ry, e_gx, e_gy;
  logic [SW-1:0] e_sp;
  logic [CW-1:0] age_ext;

  always_comb begin
    age_ext = (state_r == S_PUSH) ? '0 : CW'(pa_r);
    ent_ok  = age_ext < cnt_r;
    {e_sp, e_gy, e_gx, e_ry, e_rx} = ent_ok ? rdata : '0;
  end

  // Push stage: spread of the new frame
  logic          red_mv, grn_mv;
  logic [C-1:0]  dxa, dya;
  logic [SW-1:0] spread;

  always_comb begin
    red_mv = (rx_r != '0) && (ry_r != '0) && (e_rx != '0) && (e_ry != '0) &&
             ((rx_r != e_rx) || (ry_r != e_ry));
    grn_mv = (gx_r != '0) && (gy_r != '0) && (e_gx != '0) && (e_gy != '0) &&
             ((gx_r != e_gx) || (gy_r != e_gy));
    dxa    = (rx_r > gx_r) ? rx_r - gx_r : gx_r - rx_r;
    dya    = (ry_r > gy_r) ? ry_r - gy_r : gy_r - ry_r;
    spread = (red_mv && grn_mv) ? (SW'(dxa) * SW'(dxa) + SW'(dya) * SW'(dya)) : '0;
  end

  always_comb begin
    head_inc = (head_r == LAST) ? '0 : head_r + AW'(1);
    mem_we   = (state_r == S_PUSH);
    waddr    = head_inc;
    wdata    = {spread, gy_r, gx_r, ry_r, rx_r};
    if (state_r == S_WALK) begin
      if (head_r >= rd_i_r[AW-1:0] && rd_i_r[AW] == 1'b0) begin
        raddr = head_r - rd_i_r[AW-1:0];
      end else begin
        raddr = AW'((AW+1)'(head_r) + (AW+1)'(WINDOW_DEPTH) - rd_i_r);
      end
    end else begin
      raddr = head_r;
    end
  end

  // Walk stage tests
  ptgc_pkg::gesture_t   zoom_n, scroll_n, final_g;
  logic                 pair_mv;
  logic signed [TW-1:0] tx_n, ty_n, lo, hi;
  logic                 minor_x, minor_y;

  always_comb begin
    zoom_n = zoom_r;
    if (zoom_r == ptgc_pkg::GEST_NONE && e_sp != '0) begin
      if ((SW+2)'(s0_r) > {e_sp, 2'b00}) begin
        zoom_n = ptgc_pkg::GEST_ZOOM_IN;
      end else if (s0_r != '0 && {s0_r, 2'b00} < (SW+2)'(e_sp)) begin
        zoom_n = ptgc_pkg::GEST_ZOOM_OUT;
      end
    end
    pair_mv = (px_r != '0) && (py_r != '0) && (e_rx != '0) && (e_ry != '0) &&
              ((px_r != e_rx) || (py_r != e_ry));
    tx_n = tx_r + $signed(TW'(e_rx)) - $signed(TW'(px_r));
    ty_n = ty_r + $signed(TW'(e_ry)) - $signed(TW'(py_r));
    lo   = $signed(TW'(lim.minor));
    hi   = $signed(TW'(lim.major));
    minor_x = (tx_n < lo) && (tx_n > -lo);
    minor_y = (ty_n < lo) && (ty_n > -lo);
    scroll_n = scroll_r;
    if (scroll_r == ptgc_pkg::GEST_NONE && pair_mv) begin
      if (ty_n > hi && minor_x) begin
        scroll_n = ptgc_pkg::GEST_UP;
      end else if (ty_n < -hi && minor_x) begin
        scroll_n = ptgc_pkg::GEST_DOWN;
      end else if (tx_n < -hi && minor_y) begin
        scroll_n = ptgc_pkg::GEST_LEFT;
      end else if (tx_n > hi && minor_y) begin
        scroll_n = ptgc_pkg::GEST_RIGHT;
      end
    end
    final_g = (zoom_r != ptgc_pkg::GEST_NONE) ? zoom_r : scroll_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
      gest_r      <= ptgc_pkg::GEST_NONE;
      zoom_r      <= ptgc_pkg::GEST_NONE;
      scroll_r    <= ptgc_pkg::GEST_NONE;
    end else begin
      // in S_DONE the result register is handled by the state itself
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            rx_r    <= in_ch.red_x;
            ry_r    <= in_ch.red_y;
            gx_r    <= in_ch.green_x;
            gy_r    <= in_ch.green_y;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          head_r   <= head_inc;
          cnt_r    <= (cnt_r == FULL) ? FULL : cnt_r + CW'(1);
          s0_r     <= spread;
          px_r     <= rx_r;
          py_r     <= ry_r;
          tx_r     <= '0;
          ty_r     <= '0;
          zoom_r   <= ptgc_pkg::GEST_NONE;
          scroll_r <= ptgc_pkg::GEST_NONE;
          rd_i_r   <= (AW+1)'(1);
          pv_r     <= 1'b0;
          state_r  <= S_WALK;
        end
        S_WALK: begin
          pv_r <= (rd_i_r <= (AW+1)'(LAST));
          pa_r <= rd_i_r[AW-1:0];
          if (rd_i_r <= (AW+1)'(LAST)) begin
            rd_i_r <= rd_i_r + (AW+1)'(1);
          end
          if (pv_r) begin
            zoom_r   <= zoom_n;
            scroll_r <= scroll_n;
            px_r     <= e_rx;
            py_r     <= e_ry;
            if (pair_mv && scroll_r == ptgc_pkg::GEST_NONE) begin
              tx_r <= tx_n;
              ty_r <= ty_n;
            end
            if (pa_r == LAST) begin
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            gest_r      <= final_g;
            if (final_g != ptgc_pkg::GEST_NONE) begin
              cnt_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = gest_r;

endmodule

@@ src/point_track_gesture_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_track_gesture_classifier
// Classifies red/green marker tracks into scroll and zoom gestures.
//
//   channel | dir | payload
//   in_ch   | in  | red_x, red_y, green_x, green_y
//   out_ch  | out | gesture
//   cfg_ch  | in  | index (0 minor limit, 1 major limit), data
//
// Each frame is handled as a read of the newest entry, push, then one memory
// read per older entry through the single read port of the window memory. A
// fill count stands in for clearing the window memory on reset and on a
// gesture. A frame is taken while the previous result still waits; the
// sequencer holds in its final state only while that result stalls.
// Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module point_track_gesture_classifier #(
  parameter int WINDOW_DEPTH = ptgc_pkg::WINDOW_DEPTH_DEF,
  parameter int COORD_BITS   = ptgc_pkg::COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptgc_in_if.sink    in_ch,
  ptgc_out_if.source out_ch,
  ptgc_cfg_if.sink   cfg_ch
);

  ptgc_pkg::limits_t lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.minor <= ptgc_pkg::MINOR_RST;
      lim_r.major <= ptgc_pkg::MAJOR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        ptgc_pkg::REG_MINOR: lim_r.minor <= cfg_ch.data[ptgc_pkg::MINOR_W-1:0];
        ptgc_pkg::REG_MAJOR: lim_r.major <= cfg_ch.data[ptgc_pkg::MAJOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  ptgc_core #(.WINDOW_DEPTH(WINDOW_DEPTH), .COORD_BITS(COORD_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .lim(lim_r), .in_ch(in_ch), .out_ch(out_ch)
  );

endmodule

@@ bench/ptgc_tb_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptgc bench interface note
// The bench reuses the block's own channel interfaces from src/ptgc_ifs.sv;
// this file only holds the shared window depth and coordinate width.
// ----------------------------------------------------------------------------
package ptgc_tb_pkg;
  localparam int TB_DEPTH = ptgc_pkg::WINDOW_DEPTH_DEF;
  localparam int TB_COORD = ptgc_pkg::COORD_BITS_DEF;
endpackage

@@ bench/point_track_gesture_classifier_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_track_gesture_classifier_tb
// Drives marker frames and register writes into the gesture classifier and
// checks every gesture against an in-bench predictor of the windows, the
// zoom test and the scroll walk. Random gaps on both channels, one long
// output stall to fill the block.
// ----------------------------------------------------------------------------
module point_track_gesture_classifier_tb;

  localparam int D = ptgc_tb_pkg::TB_DEPTH;
  localparam int CB = ptgc_tb_pkg::TB_COORD;
  localparam int IDLE_LIMIT = 20000;

  logic clk, rst_n;
  ptgc_in_if  in_ch();
  ptgc_out_if out_ch();
  ptgc_cfg_if cfg_ch();

  point_track_gesture_classifier u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [ptgc_pkg::MINOR_W-1:0] lim_minor;
  logic [ptgc_pkg::MAJOR_W-1:0] lim_major;
  logic [CB-1:0] rxw[D], ryw[D], gxw[D], gyw[D];
  logic [2*CB:0] spw[D];
  ptgc_pkg::gesture_t gesture_q[$];

  int mismatches, frames_sent, gestures_seen, idle_cycles;
  int hit_count[7];
  bit hold_off;

  function automatic bit moved(logic [CB-1:0] x0, y0, x1, y1);
    return x0 != 0 && y0 != 0 && x1 != 0 && y1 != 0 && (x0 != x1 || y0 != y1);
  endfunction

  function automatic longint sqd(logic [CB-1:0] a, b);
    longint d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  function automatic ptgc_pkg::gesture_t zoom_check();
    longint s0, si;
    s0 = spw[0];
    for (int i = 1; i < D; i++) begin
      si = spw[i];
      if (si == 0) continue;
      if (s0 > 4 * si) return ptgc_pkg::GEST_ZOOM_IN;
      if (s0 != 0 && 4 * s0 < si) return ptgc_pkg::GEST_ZOOM_OUT;
    end
    return ptgc_pkg::GEST_NONE;
  endfunction

  function automatic ptgc_pkg::gesture_t scroll_check();
    longint tx, ty, lo, hi;
    tx = 0; ty = 0;
    lo = lim_minor; hi = lim_major;
    for (int i = 1; i < D; i++) begin
      if (!moved(rxw[i-1], ryw[i-1], rxw[i], ryw[i])) continue;
      tx += longint'(rxw[i]) - longint'(rxw[i-1]);
      ty += longint'(ryw[i]) - longint'(ryw[i-1]);
      if (ty > hi && tx < lo && tx > -lo) return ptgc_pkg::GEST_UP;
      if (ty < -hi && tx < lo && tx > -lo) return ptgc_pkg::GEST_DOWN;
      if (tx < -hi && ty < lo && ty > -lo) return ptgc_pkg::GEST_LEFT;
      if (tx > hi && ty < lo && ty > -lo) return ptgc_pkg::GEST_RIGHT;
    end
    return ptgc_pkg::GEST_NONE;
  endfunction

  function automatic void clear_tracks();
    for (int i = 0; i < D; i++) begin
      rxw[i] = '0; ryw[i] = '0; gxw[i] = '0; gyw[i] = '0; spw[i] = '0;
    end
  endfunction

  function automatic ptgc_pkg::gesture_t classify_frame(logic [CB-1:0] rx, ry, gx, gy);
    ptgc_pkg::gesture_t g;
    for (int i = D - 1; i > 0; i--) begin
      rxw[i] = rxw[i-1]; ryw[i] = ryw[i-1]; gxw[i] = gxw[i-1]; gyw[i] = gyw[i-1];
      spw[i] = spw[i-1];
    end
    rxw[0] = rx; ryw[0] = ry; gxw[0] = gx; gyw[0] = gy;
    if (moved(rxw[0], ryw[0], rxw[1], ryw[1]) && moved(gxw[0], gyw[0], gxw[1], gyw[1]))
      spw[0] = (2*CB+1)'(sqd(rx, gx) + sqd(ry, gy));
    else
      spw[0] = '0;
    g = zoom_check();
    if (g == ptgc_pkg::GEST_NONE) g = scroll_check();
    if (g != ptgc_pkg::GEST_NONE) clear_tracks();
    return g;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ------------------------------------------------------------ driving
  // valid stays up between back-to-back frames; drain() drops it
  task automatic send_frame(logic [CB-1:0] rx, ry, gx, gy, bit gaps = 1);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.red_x <= rx; in_ch.red_y <= ry; in_ch.green_x <= gx; in_ch.green_y <= gy;
    do @(posedge clk); while (!in_ch.ready);
    gesture_q.push_back(classify_frame(rx, ry, gx, gy));
    frames_sent++;
    @(negedge clk);
  endtask

  task automatic drain(int tail = 80);
    in_ch.valid <= 1'b0;
    while (gesture_q.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_limit(ptgc_pkg::reg_idx_t idx, logic [ptgc_pkg::CFG_DAT_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == ptgc_pkg::REG_MINOR) lim_minor = val[ptgc_pkg::MINOR_W-1:0];
    else lim_major = val[ptgc_pkg::MAJOR_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_limits(logic [ptgc_pkg::CFG_DAT_W-1:0] mn, mj);
    drain();
    write_limit(ptgc_pkg::REG_MINOR, mn);
    write_limit(ptgc_pkg::REG_MAJOR, mj);
    cfg_ch.valid <= 1'b0;
  endtask

  // straight red track only, clamped to 1..2047; step may be signed
  task automatic red_track(int x0, y0, dx, dy, int n);
    int x, y;
    for (int k = 0; k < n; k++) begin
      x = x0 + k * dx; y = y0 + k * dy;
      if (x < 1) x = 1; if (x > 2047) x = 2047;
      if (y < 1) y = 1; if (y > 2047) y = 2047;
      send_frame(CB'(x), CB'(y), '0, '0);
    end
  endtask

  // ------------------------------------------------------------ receiving
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      int n;
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 25) begin
        n = gap_len();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
      end else out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (gesture_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected gesture %0d", $realtime, out_ch.gesture);
      end else begin
        ptgc_pkg::gesture_t want;
        want = gesture_q.pop_front();
        gestures_seen++;
        hit_count[want]++;
        if (out_ch.gesture !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] gesture exp %0d got %0d", $realtime, want, out_ch.gesture);
        end
      end
    end
  end

  // watchdog on transaction-free cycles
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || hold_off)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired");
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------ tests
  task automatic test_edges();
    send_frame('0, '0, '0, '0);
    send_frame(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
    send_frame(11'h001, 11'h001, 11'h001, 11'h001);
    send_frame(11'h7FF, 11'h001, 11'h001, 11'h7FF);
    send_frame(11'h001, 11'h7FF, 11'h7FF, 11'h001);
    send_frame(11'h555, 11'h2AA, 11'h2AA, 11'h555);
    send_frame(11'h555, 11'h2AA, 11'h2AA, 11'h555); // no motion
    send_frame(11'h400, 11'h000, 11'h100, 11'h100); // red lost
  endtask

  // zero frames do not clear the model, so this just breaks motion chains
  task automatic clear_track_via_idle();
    send_frame('0, '0, '0, '0);
  endtask

  task automatic test_zoom();
    clear_track_via_idle();
    // markers spread apart: zoom in
    for (int k = 0; k < 4; k++)
      send_frame(CB'(1000 - 10 - 60*k), CB'(500 + k), CB'(1000 + 10 + 60*k), CB'(500 + k));
    // markers close in: zoom out
    for (int k = 0; k < 4; k++)
      send_frame(CB'(700 + 80*k), CB'(900 + k), CB'(1300 - 80*k), CB'(900 + k));
  endtask

  // totals are older minus newer, so a rising row reads as down
  task automatic test_scrolls();
    red_track(1000, 200, 0, 40, 10);   // down
    clear_track_via_idle();
    red_track(1000, 1800, 0, -40, 10); // up
    clear_track_via_idle();
    red_track(1800, 1000, -40, 0, 10); // right
    clear_track_via_idle();
    red_track(200, 1000, 40, 0, 10);   // left
  endtask

  task automatic test_random(int n_frames);
    int done, kind, x, y, gx, gy, dx, dy, len;
    done = 0;
    while (done < n_frames) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(3, 14);
      x = $urandom_range(300, 1700); y = $urandom_range(300, 1700);
      gx = $urandom_range(300, 1700); gy = $urandom_range(300, 1700);
      if (kind < 4) begin
        dx = $urandom_range(0, 1) ? $urandom_range(0, 4) - 2 : $urandom_range(0, 80) - 40;
        dy = $urandom_range(0, 1) ? $urandom_range(0, 80) - 40 : $urandom_range(0, 4) - 2;
        red_track(x, y, dx, dy, len);
      end else if (kind < 7) begin
        dx = $urandom_range(0, 60) - 30; dy = $urandom_range(0, 6) - 3;
        for (int k = 0; k < len; k++)
          send_frame(CB'(x + k), CB'(y + k*dy), CB'(gx + k*dx), CB'(gy + k));
      end else begin
        for (int k = 0; k < len; k++)
          send_frame(CB'($urandom_range(0, 2047) * ($urandom_range(0, 5) != 0)),
                     CB'($urandom_range(0, 2047)), CB'($urandom_range(0, 2047)),
                     CB'($urandom_range(0, 2047) * ($urandom_range(0, 5) != 0)));
      end
      done += len;
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 12; k++)
        send_frame(CB'(900), CB'(300 + 50*k), CB'(0), CB'(0), 0);
    join
  endtask

  initial begin
    rst_n = 1'b0;
    hold_off = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.red_x = '0; in_ch.red_y = '0; in_ch.green_x = '0; in_ch.green_y = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = ptgc_pkg::REG_MINOR; cfg_ch.data = '0;
    mismatches = 0; frames_sent = 0; gestures_seen = 0; idle_cycles = 0;
    foreach (hit_count[i]) hit_count[i] = 0;
    lim_minor = ptgc_pkg::MINOR_RST; lim_major = ptgc_pkg::MAJOR_RST;
    clear_tracks();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edges();
    test_zoom();
    test_scrolls();
    test_backpressure();
    set_limits(16'd4095, 16'd0);
    test_random(60);
    set_limits(16'd0, 16'd65535);
    test_random(40);
    set_limits(16'd10, 16'd100);
    test_random(120);
    set_limits(16'hFFFF, 16'd1);
    test_random(40);
    set_limits(16'd50, 16'd300);
    test_random(100);
    drain();

    $display("%0d frames, %0d gestures checked; none/up/down/left/right/in/out:",
             frames_sent, gestures_seen);
    $display("  %0d %0d %0d %0d %0d %0d %0d", hit_count[0], hit_count[1],
             hit_count[2], hit_count[3], hit_count[4], hit_count[5], hit_count[6]);
    if (mismatches == 0 && gesture_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
